// ----- design/qdr_pkg.sv -----
// ----------------------------------------------------------------------------
// qdr_pkg
// shared constants, types and the pin pattern table of the quadrature readout
// ----------------------------------------------------------------------------
`default_nettype none

package qdr_pkg;

  localparam int unsigned NumChannelsDefault = 3;
  localparam int unsigned MaxReadChannels    = 3;
  localparam int unsigned PinsWidth          = 6;
  localparam int unsigned WordWidth          = 16;
  localparam int unsigned ByteWidth          = 8;
  localparam int unsigned ReplyBytes         = 2 * MaxReadChannels;
  localparam int unsigned ReplyWidth         = ReplyBytes * ByteWidth;
  localparam int unsigned CountWidth         = $clog2(ReplyBytes + 1);

  localparam logic [WordWidth-1:0] PositionReset = 16'd10000;
  localparam logic [WordWidth-1:0] PresetReset   = 16'd9700;
  localparam logic [WordWidth-1:0] PositionMax   = 16'hFFFF;

  // request kinds
  localparam logic OpSample  = 1'b0;
  localparam logic OpCommand = 1'b1;

  // command bytes
  localparam logic [ByteWidth-1:0] CmdReadPos  = 8'h55;
  localparam logic [ByteWidth-1:0] CmdReadErr  = 8'hAA;
  localparam logic [ByteWidth-1:0] CmdResetPos = 8'hBB;

  // phase steps
  localparam logic [1:0] StepNone = 2'd0;
  localparam logic [1:0] StepFwd  = 2'd1;
  localparam logic [1:0] StepJump = 2'd2;
  localparam logic [1:0] StepRev  = 2'd3;

  typedef struct packed {
    logic sample;
    logic load;
  } chan_ctrl_t;

  typedef struct packed {
    logic                  load;
    logic [ReplyWidth-1:0] data;
    logic [CountWidth-1:0] count;
  } reply_load_t;

  // gray sequence index of a pin pattern (pin1 pin0)
  function automatic logic [1:0] pattern_to_phase(input logic [1:0] pat);
    logic [1:0] idx;
    unique case (pat)
      2'b00:   idx = 2'd0;
      2'b01:   idx = 2'd3;
      2'b10:   idx = 2'd1;
      default: idx = 2'd2;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- design/qdr_ifs.sv -----
// ----------------------------------------------------------------------------
// qdr interfaces
// request, reply and preset write channels with valid/ready handshakes
// ----------------------------------------------------------------------------
`default_nettype none

interface qdr_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] pins;
  logic [7:0] command_byte;
  modport source (output valid, op, pins, command_byte, input ready);
  modport sink   (input valid, op, pins, command_byte, output ready);
endinterface

interface qdr_reply_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;
  modport source (output valid, tx_byte, last, input ready);
  modport sink   (input valid, tx_byte, last, output ready);
endinterface

interface qdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] position_preset;
  modport source (output valid, position_preset, input ready);
  modport sink   (input valid, position_preset, output ready);
endinterface

`default_nettype wire

// ----- design/qdr_channel.sv -----
// ----------------------------------------------------------------------------
// qdr_channel
// one decoder channel: phase, position and error count
// ----------------------------------------------------------------------------
`default_nettype none

module qdr_channel
  import qdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire chan_ctrl_t           ctrl,
  input  wire logic [1:0]           pat,
  input  wire logic [WordWidth-1:0] preset,
  output logic      [WordWidth-1:0] position,
  output logic      [WordWidth-1:0] error_count
);

  logic [1:0]           phase;
  logic [1:0]           phase_next;
  logic [1:0]           step;
  logic [WordWidth-1:0] pos_base;
  logic [WordWidth-1:0] position_next;
  logic [WordWidth-1:0] error_count_next;

  always_comb begin
    phase_next       = pattern_to_phase(pat);
    step             = phase_next - phase;
    // the all-ones position folds to zero ahead of every sample
    pos_base         = (position == PositionMax) ? '0 : position;
    position_next    = pos_base;
    error_count_next = error_count;
    unique case (step)
      StepFwd:  position_next    = pos_base + 1'b1;
      StepRev:  position_next    = pos_base - 1'b1;
      StepJump: error_count_next = error_count + 1'b1;
      default:  position_next    = pos_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      position    <= PositionReset;
      error_count <= '0;
    end else if (ctrl.sample) begin
      phase       <= phase_next;
      position    <= position_next;
      error_count <= error_count_next;
    end else if (ctrl.load) begin
      position <= preset;
    end
  end

endmodule

`default_nettype wire

// ----- design/qdr_reply.sv -----
// ----------------------------------------------------------------------------
// qdr_reply
// reply byte buffer, shifts out one byte per accepted tx handshake
// ----------------------------------------------------------------------------
`default_nettype none

module qdr_reply
  import qdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire reply_load_t ld,
  output logic             free,
  qdr_reply_if.source      tx
);

  logic [ReplyWidth-1:0] bytes;
  logic [CountWidth-1:0] count;
  logic                  take;

  assign take       = tx.valid && tx.ready;
  assign free       = (count == '0) || ((count == CountWidth'(1)) && take);
  assign tx.valid   = (count != '0);
  assign tx.tx_byte = bytes[ByteWidth-1:0];
  assign tx.last    = (count == CountWidth'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ld.load) begin
      count <= ld.count;
    end else if (take) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      bytes <= ld.data;
    end else if (take) begin
      bytes <= bytes >> ByteWidth;
    end
  end

endmodule

`default_nettype wire

// ----- design/quadrature_decoder_3ch_readout_top.sv -----
// ----------------------------------------------------------------------------
// quadrature_decoder_3ch_readout_top
// multi-channel quadrature decoder with a byte command readout
// ----------------------------------------------------------------------------
//
// channel  role   payload                       handshake
// rx       sink   op, pins[5:0], command_byte   valid / ready
// tx       source tx_byte[7:0], last            valid / ready
// cfg      sink   position_preset[15:0]         valid / ready (always ready)
//
// a request is registered on entry and worked from there; the block takes a
// request every cycle unless a command waits there for the reply buffer
// a read or reset-position command fills the reply buffer, which then shifts
// out one byte per cycle while tx is ready (up to six); a further such command
// waits in the entry register until the buffer is free, pin samples in the
// meantime are not held up unless a command sits ahead of them
// reset (rst, synchronous) sets phases to 0, positions to 10000, error counts
// to 0, the preset to 9700 and empties the entry register and reply buffer
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_3ch_readout_top
  import qdr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic   clk,
  input  wire logic   rst,
  qdr_req_if.sink     rx,
  qdr_reply_if.source tx,
  qdr_cfg_if.sink     cfg
);

  // channels that a read covers
  localparam int unsigned ReadCh = (NUM_CHANNELS < MaxReadChannels) ?
                                   NUM_CHANNELS : MaxReadChannels;
  localparam logic [CountWidth-1:0] ReadBytes = CountWidth'(2 * ReadCh);

  // entry register
  logic                 st_valid;
  logic                 st_op;
  logic [PinsWidth-1:0] st_pins;
  logic [ByteWidth-1:0] st_cmd;

  logic [WordWidth-1:0] preset;

  logic [WordWidth-1:0] position    [NUM_CHANNELS];
  logic [WordWidth-1:0] error_count [NUM_CHANNELS];

  logic        is_read_pos;
  logic        is_read_err;
  logic        is_reset_pos;
  logic        needs_reply;
  logic        reply_free;
  logic        advance;
  chan_ctrl_t  chan_ctrl;
  reply_load_t reply_ld;

  // preset register, written whenever the host offers it
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preset <= PresetReset;
    end else if (cfg.valid) begin
      preset <= cfg.position_preset;
    end
  end

  // decode the held command
  always_comb begin
    is_read_pos  = 1'b0;
    is_read_err  = 1'b0;
    is_reset_pos = 1'b0;
    unique case (st_cmd)
      CmdReadPos:  is_read_pos  = 1'b1;
      CmdReadErr:  is_read_err  = 1'b1;
      CmdResetPos: is_reset_pos = 1'b1;
      default:     is_read_pos  = 1'b0;
    endcase
  end

  // commands that answer need the reply buffer; everything else moves on
  assign needs_reply = (st_op == OpCommand) &&
                       (is_read_pos || is_read_err || is_reset_pos);
  assign advance     = st_valid && (!needs_reply || reply_free);
  assign rx.ready    = !st_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (rx.ready) begin
      st_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      st_op   <= rx.op;
      st_pins <= rx.pins;
      st_cmd  <= rx.command_byte;
    end
  end

  assign chan_ctrl.sample = advance && (st_op == OpSample);
  assign chan_ctrl.load   = advance && (st_op == OpCommand) && is_reset_pos;

  // one decoder per channel; channels past the pin field see pattern 00
  for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_chan
    logic [1:0] pat;
    if (2 * ch + 1 < PinsWidth) begin : g_pins
      assign pat = st_pins[2*ch+1:2*ch];
    end else begin : g_nopins
      assign pat = 2'b00;
    end

    qdr_channel u_channel (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (chan_ctrl),
      .pat         (pat),
      .preset      (preset),
      .position    (position[ch]),
      .error_count (error_count[ch])
    );
  end

  // reply payload: words low byte first, channel 0 first; reset gives one zero
  always_comb begin
    reply_ld.load  = advance && needs_reply;
    reply_ld.data  = '0;
    reply_ld.count = ReadBytes;
    if (is_reset_pos) begin
      reply_ld.count = CountWidth'(1);
    end else begin
      for (int i = 0; i < ReadCh; i++) begin
        reply_ld.data[i*WordWidth +: WordWidth] =
          is_read_pos ? position[i] : error_count[i];
      end
    end
  end

  qdr_reply u_reply (
    .clk  (clk),
    .rst  (rst),
    .ld   (reply_ld),
    .free (reply_free),
    .tx   (tx)
  );

endmodule

`default_nettype wire
